/* sv/wps_pkg.sv */
// ----------------------------------------------------------------------------
// wps_pkg
// shared constants, types and helpers of the wildcard pattern search block
// ----------------------------------------------------------------------------
package wps_pkg;

  localparam int unsigned MaxPatternBytes = 16;
  localparam int unsigned ByteW           = 8;
  localparam int unsigned LenW            = 5;
  localparam int unsigned TapW            = 4;
  localparam int unsigned AddrW           = 48;
  localparam int unsigned OffsetW         = 32;
  localparam int unsigned WordW           = 64;
  localparam int unsigned PaddrW          = 6;
  localparam int unsigned RegIdxW         = 3;

  typedef logic [MaxPatternBytes-1:0][ByteW-1:0] window_t;
  typedef logic [LenW-1:0]                       len_t;
  typedef logic [AddrW-1:0]                      addr_t;

  typedef enum logic [RegIdxW-1:0] {
    RegPatternLow    = 3'd0,
    RegPatternHigh   = 3'd1,
    RegPatternLength = 3'd2,
    RegBaseAddress   = 3'd3,
    RegResultOffset  = 3'd4
  } reg_idx_e;

  // pending result between compare and address stages
  typedef struct packed {
    logic  found;
    addr_t start;
  } res_t;

  // clamp the configured length into 1..MaxPatternBytes
  function automatic len_t eff_len(input len_t cfg_len);
    len_t res;
    if (cfg_len == '0) begin
      res = len_t'(1);
    end else if (cfg_len > len_t'(MaxPatternBytes)) begin
      res = len_t'(MaxPatternBytes);
    end else begin
      res = cfg_len;
    end
    return res;
  endfunction

endpackage

/* sv/wps_match.sv */
// ----------------------------------------------------------------------------
// wps_match
// parallel wildcard compare of the byte window against the pattern
// ----------------------------------------------------------------------------
module wps_match (
  input  wps_pkg::window_t             win_i,
  input  logic [wps_pkg::WordW-1:0]    pattern_low_i,
  input  logic [wps_pkg::WordW-1:0]    pattern_high_i,
  input  wps_pkg::len_t                len_i,
  output logic                         hit_o
);
  import wps_pkg::*;

  window_t                        pat;
  logic [MaxPatternBytes-1:0][TapW-1:0] tap;

  assign pat = {pattern_high_i, pattern_low_i};

  // pattern byte i lines up with window entry len-1-i
  always_comb begin
    for (int i = 0; i < MaxPatternBytes; i++) begin
      tap[i] = TapW'(len_i - len_t'(1) - len_t'(i));
    end
  end

  always_comb begin
    hit_o = 1'b1;
    for (int i = 0; i < MaxPatternBytes; i++) begin
      if (len_t'(i) < len_i) begin
        if (pat[i] != '0 && win_i[tap[i]] != pat[i]) begin
          hit_o = 1'b0;
        end
      end
    end
  end

endmodule

/* sv/wildcard_pattern_search.sv */
// ----------------------------------------------------------------------------
// wildcard_pattern_search
// finds the first match of a wildcard byte pattern in a byte stream
// ----------------------------------------------------------------------------
// pipeline: a result passes the compare stage register, then the output register
// throughput: one byte per cycle; the window compare and the address add are
// each one register stage, so only a stalled output with a full stage holds off input
// reset: window, byte count, done flag and pipeline valid flags cleared; pattern length 1,
// other configuration registers zero; the result data registers are not reset
module wildcard_pattern_search (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic [wps_pkg::ByteW-1:0]    data_byte_i,
  input  logic                         last_byte_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic                         found_o,
  output logic [wps_pkg::AddrW-1:0]    match_address_o,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [wps_pkg::PaddrW-1:0]   paddr,
  input  logic [wps_pkg::WordW-1:0]    pwdata,
  output logic [wps_pkg::WordW-1:0]    prdata,
  output logic                         pready
);
  import wps_pkg::*;

  localparam addr_t SeenMax = '1;

  logic [WordW-1:0]   pattern_low_q, pattern_high_q;
  len_t               pattern_length_q;
  addr_t              base_address_q;
  logic [OffsetW-1:0] result_offset_q;

  window_t window_q, window_d;
  addr_t   bytes_seen_q, bytes_seen_d, seen_next;
  logic    search_done_q, search_done_d;

  res_t    res_a_q, res_a_d;
  logic    a_valid_q;
  logic    out_valid_q, found_q;
  addr_t   match_address_q;

  logic    cfg_wr, in_acc, out_load, a_load, win_hit, hit, res_gen;
  len_t    len;
  reg_idx_e reg_idx;

  // configuration port
  assign pready  = 1'b1;
  assign cfg_wr  = psel & penable & pwrite;
  assign reg_idx = reg_idx_e'(paddr[PaddrW-1:PaddrW-RegIdxW]);

  always_comb begin
    unique case (reg_idx)
      RegPatternLow:    prdata = pattern_low_q;
      RegPatternHigh:   prdata = pattern_high_q;
      RegPatternLength: prdata = WordW'(pattern_length_q);
      RegBaseAddress:   prdata = WordW'(base_address_q);
      RegResultOffset:  prdata = WordW'(result_offset_q);
      default:          prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pattern_low_q    <= '0;
      pattern_high_q   <= '0;
      pattern_length_q <= len_t'(1);
      base_address_q   <= '0;
      result_offset_q  <= '0;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        RegPatternLow:    pattern_low_q    <= pwdata;
        RegPatternHigh:   pattern_high_q   <= pwdata;
        RegPatternLength: pattern_length_q <= pwdata[LenW-1:0];
        RegBaseAddress:   base_address_q   <= pwdata[AddrW-1:0];
        RegResultOffset:  result_offset_q  <= pwdata[OffsetW-1:0];
        default: ;
      endcase
    end
  end

  // handshakes
  assign out_load   = !out_valid_q || out_ready_i;
  assign in_ready_o = !a_valid_q || out_load;
  assign in_acc     = in_valid_i && in_ready_o;

  // window compare
  assign len       = eff_len(pattern_length_q);
  assign seen_next = (bytes_seen_q == SeenMax) ? bytes_seen_q : bytes_seen_q + addr_t'(1);

  wps_match u_match (
    .win_i          ({window_q[MaxPatternBytes-2:0], data_byte_i}),
    .pattern_low_i  (pattern_low_q),
    .pattern_high_i (pattern_high_q),
    .len_i          (len),
    .hit_o          (win_hit)
  );

  assign hit     = !search_done_q && win_hit && (seen_next >= addr_t'(len));
  assign res_gen = in_acc && !search_done_q && (hit || last_byte_i);

  always_comb begin
    window_d      = window_q;
    bytes_seen_d  = bytes_seen_q;
    search_done_d = search_done_q;
    if (in_acc) begin
      if (!search_done_q) begin
        window_d      = {window_q[MaxPatternBytes-2:0], data_byte_i};
        bytes_seen_d  = seen_next;
        search_done_d = hit;
      end
      if (last_byte_i) begin
        window_d      = '0;
        bytes_seen_d  = '0;
        search_done_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      window_q      <= '0;
      bytes_seen_q  <= '0;
      search_done_q <= 1'b0;
    end else begin
      window_q      <= window_d;
      bytes_seen_q  <= bytes_seen_d;
      search_done_q <= search_done_d;
    end
  end

  // compare stage register
  assign res_a_d.found = hit;
  assign res_a_d.start = seen_next - addr_t'(len);
  assign a_load        = !a_valid_q || out_load;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
    end else if (a_load) begin
      a_valid_q <= res_gen;
    end
  end

  always_ff @(posedge clk_i) begin
    if (a_load && res_gen) begin
      res_a_q <= res_a_d;
    end
  end

  // address stage and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= a_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load && a_valid_q) begin
      found_q         <= res_a_q.found;
      match_address_q <= res_a_q.found
                         ? res_a_q.start + base_address_q
                           + addr_t'($signed(result_offset_q))
                         : '0;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign found_o         = found_q;
  assign match_address_o = match_address_q;

  // checks
  a_no_result_after_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && search_done_q |-> !res_gen)
    else $error("result produced after the search finished");

  a_region_end_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && last_byte_i |=> !search_done_q && bytes_seen_q == '0)
    else $error("region state not cleared after last byte");

  a_stall_only_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> a_valid_q && out_valid_q)
    else $error("input stalled with free pipeline space");

  a_not_found_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !found_o |-> match_address_o == '0)
    else $error("not-found transaction carries an address");

endmodule

/* test/tb_wildcard_pattern_search.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_wildcard_pattern_search
// drives byte regions into the wildcard pattern search block and checks every
// found / not found transaction against a predictor kept inside the bench or a
// value given in the table; a short directed table covers reset values, length
// clamping, short regions, bytes after a match and address wrap, then random
// phases reprogramme the registers and send regions with and without planted
// patterns, and outside a calm stretch apply random stalls on both sides
// ----------------------------------------------------------------------------
module tb_wildcard_pattern_search;
  import wps_pkg::*;

  typedef struct packed {
    logic  found;
    addr_t addr;
  } outcome_t;

  typedef enum logic {RowByte, RowWrite} row_kind_e;

  typedef struct packed {
    row_kind_e        kind;
    reg_idx_e         idx;
    logic [WordW-1:0] value;
    logic [ByteW-1:0] data;
    logic             last;
    logic             typed;
    outcome_t         known;
  } plan_row_t;

  logic              clk_i;
  logic              rst_ni          = 1'b0;
  logic              in_valid_i      = 1'b0;
  logic              in_ready_o;
  logic [ByteW-1:0]  data_byte_i     = '0;
  logic              last_byte_i     = 1'b0;
  logic              out_valid_o;
  logic              out_ready_i     = 1'b0;
  logic              found_o;
  logic [AddrW-1:0]  match_address_o;
  logic              psel            = 1'b0;
  logic              penable         = 1'b0;
  logic              pwrite          = 1'b0;
  logic [PaddrW-1:0] paddr           = '0;
  logic [WordW-1:0]  pwdata          = '0;
  logic [WordW-1:0]  prdata;
  logic              pready;

  // predictor state and register copies
  logic [ByteW-1:0]   win_q [MaxPatternBytes] = '{default: '0};
  addr_t              seen_q    = '0;
  logic               done_q    = 1'b0;
  logic [WordW-1:0]   pat_lo_q  = '0;
  logic [WordW-1:0]   pat_hi_q  = '0;
  len_t               pat_len_q = len_t'(1);
  addr_t              base_q    = '0;
  logic [OffsetW-1:0] offset_q  = '0;

  outcome_t    outcome_q [$];
  int unsigned mismatch_cnt = 0;
  int unsigned live_cnt     = 0;
  bit          calm         = 1'b0;

  wildcard_pattern_search dut (.*);

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #2_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

  function automatic logic [ByteW-1:0] pattern_at(input int unsigned i);
    logic [ByteW-1:0] pb;
    if (i < 8) begin
      pb = pat_lo_q[8*i +: 8];
    end else begin
      pb = pat_hi_q[8*(i-8) +: 8];
    end
    return pb;
  endfunction

  function automatic int unsigned live_length();
    int unsigned n;
    if (pat_len_q == '0) begin
      n = 1;
    end else if (pat_len_q > len_t'(MaxPatternBytes)) begin
      n = MaxPatternBytes;
    end else begin
      n = int'(pat_len_q);
    end
    return n;
  endfunction

  // one byte through the search; returns 1 when a transaction is due
  function automatic bit search_step(input logic [ByteW-1:0] d, input logic l,
                                     output outcome_t res);
    int unsigned      n;
    bit               hit;
    bit               emit;
    logic [ByteW-1:0] pb;
    res  = '0;
    emit = 1'b0;
    if (!done_q) begin
      n = live_length();
      for (int i = MaxPatternBytes - 1; i > 0; i--) win_q[i] = win_q[i-1];
      win_q[0] = d;
      if (seen_q != '1) seen_q = seen_q + 1'b1;
      hit = (seen_q >= addr_t'(n));
      for (int i = 0; i < n; i++) begin
        pb = pattern_at(i);
        if (pb != '0 && win_q[n-1-i] != pb) hit = 1'b0;
      end
      if (hit) begin
        res.found = 1'b1;
        res.addr  = base_q + (seen_q - addr_t'(n)) +
                    {{(AddrW-OffsetW){offset_q[OffsetW-1]}}, offset_q};
        done_q    = 1'b1;
        emit      = 1'b1;
      end else if (l) begin
        emit = 1'b1;
      end
    end
    if (l) begin
      foreach (win_q[k]) win_q[k] = '0;
      seen_q = '0;
      done_q = 1'b0;
    end
    return emit;
  endfunction

  function automatic plan_row_t row_b(input logic [ByteW-1:0] d, input logic l);
    plan_row_t r;
    r = '{kind: RowByte, idx: RegPatternLow, value: '0, data: d, last: l,
          typed: 1'b0, known: '0};
    return r;
  endfunction

  function automatic plan_row_t row_t(input logic [ByteW-1:0] d, input logic l,
                                      input logic f, input addr_t a);
    plan_row_t r;
    r = row_b(d, l);
    r.typed = 1'b1;
    r.known = '{found: f, addr: a};
    return r;
  endfunction

  function automatic plan_row_t row_w(input reg_idx_e idx, input logic [WordW-1:0] v);
    plan_row_t r;
    r = row_b('0, 1'b0);
    r.kind  = RowWrite;
    r.idx   = idx;
    r.value = v;
    return r;
  endfunction

  task automatic feed(input logic [ByteW-1:0] d, input logic l, input logic typed,
                      input outcome_t known);
    outcome_t res;
    logic     rdy;
    live_cnt++;
    if (search_step(d, l, res)) outcome_q.push_back(typed ? known : res);
    if (!calm) begin
      while ($urandom_range(99) < 6) begin
        in_valid_i <= 1'b0;
        @(posedge clk_i);
      end
    end
    in_valid_i  <= 1'b1;
    data_byte_i <= d;
    last_byte_i <= l;
    do begin
      @(negedge clk_i);
      rdy = in_ready_o;
      @(posedge clk_i);
    end while (!rdy);
  endtask

  // wait for every pending transaction, then let the pipeline empty
  task automatic settle();
    in_valid_i <= 1'b0;
    while (outcome_q.size() != 0) @(posedge clk_i);
    repeat (6) @(posedge clk_i);
  endtask

  task automatic write_reg(input reg_idx_e idx, input logic [WordW-1:0] value);
    logic rdy;
    settle();
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= PaddrW'({idx, 3'b000});
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    do begin
      @(negedge clk_i);
      rdy = pready;
      @(posedge clk_i);
    end while (!rdy);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
    case (idx)
      RegPatternLow: begin
        pat_lo_q = value;
      end
      RegPatternHigh: begin
        pat_hi_q = value;
      end
      RegPatternLength: begin
        pat_len_q = value[LenW-1:0];
      end
      RegBaseAddress: begin
        base_q = value[AddrW-1:0];
      end
      RegResultOffset: begin
        offset_q = value[OffsetW-1:0];
      end
      default: begin
      end
    endcase
  endtask

  always begin : sink
    logic     took;
    outcome_t got;
    outcome_t want;
    @(negedge clk_i);
    took      = rst_ni && out_valid_o && out_ready_i;
    got.found = found_o;
    got.addr  = match_address_o;
    @(posedge clk_i);
    out_ready_i <= calm || ($urandom_range(99) >= 6);
    if (took) begin
      if (outcome_q.size() == 0) begin
        mismatch_cnt++;
        if (mismatch_cnt <= 10) begin
          $display("unexpected transaction: found %0b address %h", got.found, got.addr);
        end
      end else begin
        want = outcome_q.pop_front();
        if (want !== got) begin
          mismatch_cnt++;
          if (mismatch_cnt <= 10) begin
            $display("mismatch: expected found %0b address %h, got found %0b address %h",
                     want.found, want.addr, got.found, got.addr);
          end
        end
      end
    end
  end

  initial begin : stimulus
    plan_row_t        directed_tbl [$];
    int unsigned      phase;
    int unsigned      nreg;
    int unsigned      span;
    int unsigned      at;
    int unsigned      n;
    bit               plant;
    bit               cut;
    logic [ByteW-1:0] b;
    logic [WordW-1:0] lo;
    logic [WordW-1:0] hi;
    len_t             len;
    logic [OffsetW-1:0] offs;
    addr_t            base;

    directed_tbl = '{
      row_t(8'h00, 1'b0, 1'b1, '0),
      row_b(8'hFF, 1'b1),
      row_t(8'hFF, 1'b1, 1'b1, '0),
      row_w(RegPatternLow, 64'h0000_0000_00FF_00AB),
      row_w(RegPatternLength, 64'd3),
      row_w(RegBaseAddress, 64'h0000_FFFF_FFFF_FFFF),
      row_w(RegResultOffset, 64'h0000_0000_8000_0000),
      row_b(8'hAB, 1'b0),
      row_t(8'h12, 1'b1, 1'b0, '0),
      row_b(8'h00, 1'b0),
      row_b(8'hAB, 1'b0),
      row_b(8'h55, 1'b0),
      row_b(8'hFF, 1'b0),
      row_b(8'h01, 1'b1),
      row_w(RegPatternLength, 64'd0),
      row_w(RegPatternLow, 64'h0000_0000_0000_0080),
      row_w(RegBaseAddress, 64'd0),
      row_w(RegResultOffset, 64'h0000_0000_7FFF_FFFF),
      row_b(8'h7F, 1'b0),
      row_b(8'h80, 1'b1),
      row_t(8'h01, 1'b1, 1'b0, '0),
      row_w(RegPatternLength, 64'd31),
      row_w(RegPatternHigh, 64'hFFFF_FFFF_FFFF_FFFF),
      row_w(RegResultOffset, 64'h0000_0000_FFFF_FFFF),
      row_b(8'hFF, 1'b0),
      row_b(8'hFF, 1'b0),
      row_t(8'hFF, 1'b1, 1'b0, '0),
      row_w(RegPatternLength, 64'd1),
      row_w(RegPatternLow, 64'd0),
      row_t(8'h5A, 1'b1, 1'b1, 48'hFFFF_FFFF_FFFF)
    };

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_tbl[r]) begin
      if (directed_tbl[r].kind == RowWrite) begin
        write_reg(directed_tbl[r].idx, directed_tbl[r].value);
      end else begin
        feed(directed_tbl[r].data, directed_tbl[r].last, directed_tbl[r].typed,
             directed_tbl[r].known);
      end
    end

    live_cnt = 0;
    phase    = 0;
    while (live_cnt < 900) begin
      phase++;
      // long stretch with no stalls on either side
      calm = (phase >= 8 && phase < 12);

      case ($urandom_range(5))
        0: len = '0;
        1: len = len_t'(MaxPatternBytes);
        2: len = len_t'($urandom_range(17, 31));
        default: len = len_t'($urandom_range(1, 6));
      endcase
      for (int i = 0; i < 8; i++) begin
        lo[8*i +: 8] = ($urandom_range(3) == 0) ? 8'h00 :
                       ($urandom_range(1) ? 8'($urandom) : 8'($urandom_range(1, 3)));
        hi[8*i +: 8] = ($urandom_range(3) == 0) ? 8'h00 :
                       ($urandom_range(1) ? 8'($urandom) : 8'($urandom_range(1, 3)));
      end
      case ($urandom_range(3))
        0: base = '0;
        1: base = '1;
        default: base = {16'($urandom), 32'($urandom)};
      endcase
      case ($urandom_range(4))
        0: offs = 32'h8000_0000;
        1: offs = 32'h7FFF_FFFF;
        2: offs = 32'($urandom);
        3: offs = 32'($urandom_range(0, 64)) - 32'd32;
        default: offs = '0;
      endcase
      write_reg(RegPatternLength, WordW'(len));
      write_reg(RegPatternLow, lo);
      write_reg(RegPatternHigh, hi);
      write_reg(RegBaseAddress, WordW'(base));
      write_reg(RegResultOffset, WordW'(offs));

      n    = live_length();
      nreg = $urandom_range(2, 6);
      for (int r = 0; r < nreg; r++) begin
        span  = ($urandom_range(9) == 0) ? $urandom_range(16, 40) : $urandom_range(1, 16);
        plant = ($urandom_range(9) < 6) && (span >= n);
        at    = plant ? $urandom_range(0, span - n) : 0;
        // sometimes leave the region open across the next register change
        cut   = (r == nreg - 1) && ($urandom_range(3) == 0);
        for (int k = 0; k < span; k++) begin
          if (plant && k >= at && k < at + n && pattern_at(k - at) != '0) begin
            b = pattern_at(k - at);
          end else begin
            b = $urandom_range(1) ? 8'($urandom) : 8'($urandom_range(1, 3));
          end
          feed(b, (k == span - 1) && !cut, 1'b0, '0);
        end
      end
    end

    calm = 1'b0;
    settle();
    if (mismatch_cnt == 0 && outcome_q.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
